[design/kcp_pkg.sv]
package kcp_pkg;

    // Field widths of the query and result words.
    localparam int KCP_FIELD_W  = 20;
    localparam int KCP_ANSWER_W = 40;

    // A divisor term is a product of distinct primes of the modulus, so its
    // magnitude never exceeds the modulus; one more bit keeps headroom.
    localparam int KCP_MAG_W  = KCP_FIELD_W + 1;
    localparam int KCP_TERM_W = KCP_MAG_W + 1;

    // Trial divisors never exceed the square root of a 20-bit value plus one.
    localparam int KCP_TRIAL_W = KCP_FIELD_W / 2 + 1;

    // Signed running sum of the inclusion-exclusion count.
    localparam int KCP_SUM_W = KCP_ANSWER_W + 8;

    // Default build settings.
    localparam int                     KCP_MAX_PRIMES  = 7;
    localparam logic [KCP_ANSWER_W-1:0] KCP_SEARCH_HIGH = 40'd1000000000000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAC,
        ST_FAC_WAIT,
        ST_BUILD,
        ST_CNT_RD,
        ST_CNT_GO,
        ST_CNT_WAIT,
        ST_CNT_END,
        ST_SEARCH,
        ST_DONE
    } kcp_state_t;

    // Request to the bit-serial divider.
    typedef struct packed {
        logic                    start;
        logic [KCP_ANSWER_W-1:0] dividend;
        logic [KCP_MAG_W-1:0]    divisor;
    } kcp_div_req_t;

    // Response from the bit-serial divider.
    typedef struct packed {
        logic                    done;
        logic [KCP_ANSWER_W-1:0] quotient;
        logic [KCP_MAG_W-1:0]    remainder;
    } kcp_div_rsp_t;

endpackage

[design/kcp_divider.sv]
module kcp_divider
    import kcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  kcp_div_req_t req,
    output kcp_div_rsp_t rsp
);

    localparam int STEP_W = $clog2(KCP_ANSWER_W + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [KCP_ANSWER_W-1:0] quo_reg, quo_next;
    logic [KCP_MAG_W-1:0]    rem_reg, rem_next;
    logic [KCP_MAG_W-1:0]    dvs_reg, dvs_next;

    logic [KCP_MAG_W:0] trial;
    logic [KCP_MAG_W:0] trial_diff;
    logic               trial_ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial      = {rem_reg, quo_reg[KCP_ANSWER_W-1]};
    assign trial_ge   = trial >= {1'b0, dvs_reg};
    assign trial_diff = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[KCP_ANSWER_W-2:0], trial_ge};
            rem_next = trial_ge ? trial_diff[KCP_MAG_W-1:0] : trial[KCP_MAG_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(KCP_ANSWER_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[design/kth_coprime_after_start.sv]
// Finds the rank-th integer above start_value that is coprime to modulus_value,
// or SEARCH_HIGH when that integer is not below SEARCH_HIGH. One query is worked
// at a time; a new word is taken as soon as the previous result sits in the
// output register. All divisions run through one bit-serial divider. The
// modulus is factored by trial division, up to about 1024 divisions for a
// large prime modulus. The 2^k signed divisor terms (k distinct primes, at
// most MAX_PRIMES) are then built one after another, each by multiplying in
// the primes that its mask selects. Every count evaluation takes one division
// per term, and one query needs one evaluation for the start value plus one
// per binary-search step (about 40 steps at the default SEARCH_HIGH).
module kth_coprime_after_start
    import kcp_pkg::*;
#(
    parameter int                      MAX_PRIMES  = KCP_MAX_PRIMES,
    parameter logic [KCP_ANSWER_W-1:0] SEARCH_HIGH = KCP_SEARCH_HIGH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [KCP_FIELD_W-1:0]  start_value,
    input  logic [KCP_FIELD_W-1:0]  modulus_value,
    input  logic [KCP_FIELD_W-1:0]  rank,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [KCP_ANSWER_W-1:0] answer
);

    localparam int TERM_SLOTS = 1 << MAX_PRIMES;
    localparam int CNT_W      = $clog2(MAX_PRIMES + 1);
    localparam int PIDX_W     = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

    kcp_state_t state_reg, state_next;

    // Query word.
    logic [KCP_FIELD_W-1:0] start_reg, start_next;
    logic [KCP_FIELD_W-1:0] rank_reg, rank_next;

    // Factoring.
    logic [KCP_FIELD_W-1:0] n_reg, n_next;
    logic [KCP_TRIAL_W-1:0] d_reg, d_next;
    logic [KCP_FIELD_W-1:0] last_prime_reg, last_prime_next;
    logic [CNT_W-1:0]       prime_count_reg, prime_count_next;
    logic [KCP_FIELD_W-1:0] primes_reg [MAX_PRIMES];
    logic                   prime_wr;
    logic [KCP_FIELD_W-1:0] prime_val;

    // Term building.
    logic [MAX_PRIMES:0]  mask_reg, mask_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [KCP_MAG_W-1:0] prod_reg, prod_next;
    logic                 odd_reg, odd_next;
    logic                 term_wr;
    logic [MAX_PRIMES:0]  term_total;
    logic [KCP_MAG_W+KCP_FIELD_W-1:0] prod_wide;

    // Term store and counting.
    logic [KCP_TERM_W-1:0]   term_mem [TERM_SLOTS];
    logic [KCP_TERM_W-1:0]   term_rd_reg;
    logic [MAX_PRIMES-1:0]   idx_reg, idx_next;
    logic [KCP_ANSWER_W-1:0] m_reg, m_next;
    logic signed [KCP_SUM_W-1:0] sum_reg, sum_next;
    logic signed [KCP_SUM_W-1:0] base_reg, base_next;
    logic signed [KCP_SUM_W-1:0] quot_s;
    logic signed [KCP_SUM_W-1:0] diff;
    logic                    is_base_reg, is_base_next;

    // Search window and result.
    logic [KCP_ANSWER_W-1:0] lo_reg, lo_next;
    logic [KCP_ANSWER_W-1:0] hi_reg, hi_next;
    logic [KCP_ANSWER_W-1:0] res_reg, res_next;
    logic [KCP_ANSWER_W-1:0] answer_reg, answer_next;
    logic                    out_valid_reg, out_valid_next;

    logic [2*KCP_TRIAL_W-1:0] d_sq;
    logic                     prime_new;

    kcp_div_req_t div_req;
    kcp_div_rsp_t div_rsp;

    kcp_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign d_sq       = d_reg * d_reg;
    assign term_total = (MAX_PRIMES + 1)'(1) << prime_count_reg;
    assign prod_wide  = prod_reg * primes_reg[j_reg[PIDX_W-1:0]];
    assign quot_s     = $signed({{(KCP_SUM_W - KCP_ANSWER_W){1'b0}}, div_rsp.quotient});
    assign diff       = sum_reg - base_reg;

    // A prime is kept when it differs from the last one kept and room remains.
    assign prime_new = ((prime_count_reg == '0) || (last_prime_reg != prime_val))
                       && (prime_count_reg < CNT_W'(MAX_PRIMES));

    // Sequencer: factor, build terms, count at the start, then binary search.
    always_comb
    begin
        state_next       = state_reg;
        start_next       = start_reg;
        rank_next        = rank_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        last_prime_next  = last_prime_reg;
        prime_count_next = prime_count_reg;
        prime_wr         = 1'b0;
        prime_val        = d_sq[KCP_FIELD_W-1:0];
        mask_next        = mask_reg;
        j_next           = j_reg;
        prod_next        = prod_reg;
        odd_next         = odd_reg;
        term_wr          = 1'b0;
        idx_next         = idx_reg;
        m_next           = m_reg;
        sum_next         = sum_reg;
        base_next        = base_reg;
        is_base_next     = is_base_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        res_next         = res_reg;
        answer_next      = answer_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        div_req.start    = 1'b0;
        div_req.dividend = m_reg;
        div_req.divisor  = term_rd_reg[KCP_MAG_W-1:0];
        prime_val        = n_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    start_next       = start_value;
                    rank_next        = rank;
                    n_next           = modulus_value;
                    d_next           = KCP_TRIAL_W'(2);
                    prime_count_next = '0;
                    state_next       = ST_FAC;
                end
            end

            ST_FAC:
            begin
                if (n_reg <= KCP_FIELD_W'(1))
                begin
                    mask_next  = '0;
                    j_next     = '0;
                    prod_next  = KCP_MAG_W'(1);
                    odd_next   = 1'b0;
                    state_next = ST_BUILD;
                end
                else if (d_sq > (2*KCP_TRIAL_W)'(n_reg))
                begin
                    // What is left is itself prime.
                    prime_val = n_reg;
                    if (prime_new)
                    begin
                        prime_wr         = 1'b1;
                        last_prime_next  = n_reg;
                        prime_count_next = prime_count_reg + CNT_W'(1);
                    end
                    n_next = KCP_FIELD_W'(1);
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = KCP_ANSWER_W'(n_reg);
                    div_req.divisor  = KCP_MAG_W'(d_reg);
                    state_next       = ST_FAC_WAIT;
                end
            end

            ST_FAC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        prime_val = KCP_FIELD_W'(d_reg);
                        if (prime_new)
                        begin
                            prime_wr         = 1'b1;
                            last_prime_next  = KCP_FIELD_W'(d_reg);
                            prime_count_next = prime_count_reg + CNT_W'(1);
                        end
                        n_next = div_rsp.quotient[KCP_FIELD_W-1:0];
                    end
                    else
                    begin
                        d_next = d_reg + KCP_TRIAL_W'(1);
                    end
                    state_next = ST_FAC;
                end
            end

            ST_BUILD:
            begin
                if (j_reg < prime_count_reg)
                begin
                    if (mask_reg[j_reg])
                    begin
                        prod_next = prod_wide[KCP_MAG_W-1:0];
                        odd_next  = !odd_reg;
                    end
                    j_next = j_reg + CNT_W'(1);
                end
                else
                begin
                    term_wr   = 1'b1;
                    j_next    = '0;
                    prod_next = KCP_MAG_W'(1);
                    odd_next  = 1'b0;
                    mask_next = mask_reg + (MAX_PRIMES + 1)'(1);
                    if (mask_reg + (MAX_PRIMES + 1)'(1) == term_total)
                    begin
                        m_next       = KCP_ANSWER_W'(start_reg);
                        is_base_next = 1'b1;
                        idx_next     = '0;
                        sum_next     = '0;
                        state_next   = ST_CNT_RD;
                    end
                end
            end

            ST_CNT_RD:
            begin
                state_next = ST_CNT_GO;
            end

            ST_CNT_GO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_CNT_WAIT;
            end

            ST_CNT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (term_rd_reg[KCP_TERM_W-1])
                    begin
                        sum_next = sum_reg - quot_s;
                    end
                    else
                    begin
                        sum_next = sum_reg + quot_s;
                    end
                    if ({1'b0, idx_reg} + (MAX_PRIMES + 1)'(1) == term_total)
                    begin
                        state_next = ST_CNT_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + MAX_PRIMES'(1);
                        state_next = ST_CNT_RD;
                    end
                end
            end

            ST_CNT_END:
            begin
                if (is_base_reg)
                begin
                    base_next = sum_reg;
                    lo_next   = KCP_ANSWER_W'(start_reg) + KCP_ANSWER_W'(1);
                    hi_next   = SEARCH_HIGH;
                    res_next  = SEARCH_HIGH;
                end
                else if (diff >= $signed({{(KCP_SUM_W - KCP_FIELD_W){1'b0}}, rank_reg}))
                begin
                    res_next = m_reg;
                    hi_next  = m_reg;
                end
                else
                begin
                    lo_next = m_reg + KCP_ANSWER_W'(1);
                end
                state_next = ST_SEARCH;
            end

            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    m_next       = lo_reg + ((hi_reg - lo_reg) >> 1);
                    is_base_next = 1'b0;
                    idx_next     = '0;
                    sum_next     = '0;
                    state_next   = ST_CNT_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hand over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    answer_next    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            prime_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            prime_count_reg <= prime_count_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        rank_reg       <= rank_next;
        n_reg          <= n_next;
        d_reg          <= d_next;
        last_prime_reg <= last_prime_next;
        mask_reg       <= mask_next;
        j_reg          <= j_next;
        prod_reg       <= prod_next;
        odd_reg        <= odd_next;
        idx_reg        <= idx_next;
        m_reg          <= m_next;
        sum_reg        <= sum_next;
        base_reg       <= base_next;
        is_base_reg    <= is_base_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_reg        <= res_next;
        answer_reg     <= answer_next;
    end

    // Distinct primes of the modulus, smallest first.
    always_ff @(posedge clk)
    begin
        if (prime_wr)
        begin
            primes_reg[prime_count_reg[PIDX_W-1:0]] <= prime_val;
        end
    end

    // Signed divisor term store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (term_wr)
        begin
            term_mem[mask_reg[MAX_PRIMES-1:0]] <= {odd_reg, prod_reg};
        end
        term_rd_reg <= term_mem[idx_reg];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;

endmodule

[design/kcp_checker.sv]
module kcp_checker
    import kcp_pkg::*;
#(
    parameter logic [KCP_ANSWER_W-1:0] SEARCH_HIGH = KCP_SEARCH_HIGH
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [KCP_ANSWER_W-1:0] answer
);

    // A result word waiting to be taken holds steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(answer))
        else $error("result word changed while stalled");

    // The answer always lies strictly above zero.
    a_answer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> answer != '0)
        else $error("zero answer");

    // The answer never exceeds the search limit.
    a_answer_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> answer <= SEARCH_HIGH)
        else $error("answer above search limit");

    // Once a query word is taken the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("query word taken while busy");

endmodule

bind kth_coprime_after_start kcp_checker #(.SEARCH_HIGH(SEARCH_HIGH)) u_kcp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .answer    (answer)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import kcp_pkg::*;

    localparam int          MAX_PRIMES  = KCP_MAX_PRIMES;
    localparam int          TERM_SLOTS  = 1 << MAX_PRIMES;
    localparam longint      CYCLE_LIMIT = 150_000_000;
    localparam int          DRAIN_WAIT  = 200;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [KCP_FIELD_W-1:0]  start_value;
    logic [KCP_FIELD_W-1:0]  modulus_value;
    logic [KCP_FIELD_W-1:0]  rank;
    logic                    out_valid;
    logic                    out_ready;
    logic [KCP_ANSWER_W-1:0] answer;

    // Answers still owed by the block, oldest first.
    logic [KCP_ANSWER_W-1:0] pending_answers[$];

    // Divisor terms of the query being predicted.
    longint unsigned term_mag[TERM_SLOTS];
    bit              term_neg[TERM_SLOTS];
    int              term_total;

    int     fail_count;
    longint cycle_count;
    int     burst_left;
    int     hold_cycles;
    int     stall_mode;
    int     stall_span;

    kth_coprime_after_start uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_value   (start_value),
        .modulus_value (modulus_value),
        .rank          (rank),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .answer        (answer)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Smallest prime factor of n, for n of two or more.
    function automatic longint unsigned least_prime(longint unsigned n);
        longint unsigned d;
        d = 2;
        while (d * d <= n)
        begin
            if (n % d == 0)
                return d;
            d++;
        end
        return n;
    endfunction

    // Forms the signed square-free divisor terms of the modulus.
    function automatic void form_terms(longint unsigned n);
        longint unsigned primes[MAX_PRIMES];
        longint unsigned p;
        longint unsigned prod;
        int              count;
        bit              odd;
        count = 0;
        while (n > 1)
        begin
            p = least_prime(n);
            if ((count == 0 || primes[count-1] != p) && count < MAX_PRIMES)
            begin
                primes[count] = p;
                count++;
            end
            n = n / p;
        end
        term_total = 1 << count;
        for (int mask = 0; mask < term_total; mask++)
        begin
            prod = 1;
            odd  = 1'b0;
            for (int j = 0; j < count; j++)
            begin
                if ((mask >> j) & 1)
                begin
                    prod = prod * primes[j];
                    odd  = !odd;
                end
            end
            term_mag[mask] = prod;
            term_neg[mask] = odd;
        end
    endfunction

    // Number of integers in 1..v that are coprime to the modulus.
    function automatic longint coprimes_up_to(longint unsigned v);
        longint total;
        total = 0;
        for (int i = 0; i < term_total; i++)
        begin
            if (term_neg[i])
                total = total - longint'(v / term_mag[i]);
            else
                total = total + longint'(v / term_mag[i]);
        end
        return total;
    endfunction

    // Expected answer: binary search over the coprime count.
    function automatic logic [KCP_ANSWER_W-1:0] kth_coprime(
        logic [KCP_FIELD_W-1:0] s, logic [KCP_FIELD_W-1:0] m,
        logic [KCP_FIELD_W-1:0] r);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned found;
        longint          base;
        form_terms(longint'(m));
        lo    = longint'(s) + 1;
        hi    = longint'(KCP_SEARCH_HIGH);
        found = longint'(KCP_SEARCH_HIGH);
        base  = coprimes_up_to(longint'(s));
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (coprimes_up_to(mid) - base >= longint'(r))
            begin
                found = mid;
                hi    = mid;
            end
            else
                lo = mid + 1;
        end
        return found[KCP_ANSWER_W-1:0];
    endfunction

    // Offers one word and waits until it is taken; bursts keep valid high.
    task automatic send_query(logic [KCP_FIELD_W-1:0] s, logic [KCP_FIELD_W-1:0] m,
                              logic [KCP_FIELD_W-1:0] r, bit no_gap);
        int gap;
        start_value   = s;
        modulus_value = m;
        rank          = r;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_answers = {pending_answers, kth_coprime(s, m, r)};
        @(negedge clk);
        if (no_gap)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 6);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Moduli mostly with few small primes, so that each query stays quick.
    function automatic logic [KCP_FIELD_W-1:0] pick_modulus();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return KCP_FIELD_W'($urandom_range(0, 1023));
        else if (sel < 80)
            return KCP_FIELD_W'($urandom);
        else if (sel < 90)
            return KCP_FIELD_W'($urandom_range(1, 64) * 30);
        else
            return KCP_FIELD_W'(1 << $urandom_range(0, 19));
    endfunction

    // Extremes of every field and each special case.
    task automatic test_directed();
        send_query(20'd0, 20'd0, 20'd0, 1'b0);
        send_query(20'd0, 20'd1, 20'd1, 1'b0);
        send_query(20'd1048575, 20'd1, 20'd0, 1'b0);
        send_query(20'd0, 20'd0, 20'd1048575, 1'b0);
        send_query(20'd1048575, 20'd1048575, 20'd1048575, 1'b0);
        send_query(20'd0, 20'd2, 20'd1, 1'b0);
        send_query(20'd5, 20'd6, 20'd3, 1'b0);
        send_query(20'd7, 20'd7, 20'd1, 1'b0);
        send_query(20'd12345, 20'd524288, 20'd777, 1'b0);
        send_query(20'd524288, 20'd524287, 20'd2, 1'b0);
        send_query(20'd0, 20'd1048573, 20'd1048575, 1'b0);
        send_query(20'd0, 20'd30030, 20'd5000, 1'b0);
        // Seven distinct primes, the most a 20-bit modulus holds.
        send_query(20'd100, 20'd510510, 20'd1, 1'b0);
        send_query(20'd1048575, 20'd570570, 20'd1048575, 1'b0);
        send_query(20'd699050, 20'd699050, 20'd349525, 1'b0);
    endtask

    // Random queries with random content across the full field ranges.
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_query(KCP_FIELD_W'($urandom), pick_modulus(), KCP_FIELD_W'($urandom), 1'b0);
    endtask

    // The receiver holds off while quick queries keep coming back to back.
    task automatic test_backpressure();
        hold_cycles = 30000;
        for (int i = 0; i < 6; i++)
            send_query(KCP_FIELD_W'($urandom), KCP_FIELD_W'($urandom_range(0, 63)),
                       KCP_FIELD_W'($urandom_range(0, 4095)), 1'b1);
    endtask

    // Receiver: a long hold when asked, otherwise a stall pattern of its own.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready   <= 1'b0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_span <= $urandom_range(5, 200);
            end
            else
                stall_span <= stall_span - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Each result word is checked against the oldest expected answer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("answer: none expected, got %0d", answer);
                fail_count++;
            end
            else
            begin
                if (answer !== pending_answers[0])
                begin
                    $error("answer: expected %0d, got %0d", pending_answers[0], answer);
                    fail_count++;
                end
                void'(pending_answers.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        fail_count    = 0;
        cycle_count   = 0;
        burst_left    = 0;
        hold_cycles   = 0;
        stall_mode    = 0;
        stall_span    = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        start_value   = '0;
        modulus_value = '0;
        rank          = '0;
        out_ready     = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(40);
        test_backpressure();
        test_random(40);

        // Drain the remaining answers, then allow a quiet tail.
        in_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
